FILE: rtl/dlp_pkg.sv
package dlp_pkg;

  // Character codes recognised by the scanner.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [31:0] WHOLE_CAP = 32'h8000_0000;

  // Magnitude width before saturation: a whole part of up to 2^31 shifted by
  // the widest fraction field, plus a carry from rounding.
  localparam int MAG_W = 57;
  localparam logic [MAG_W-1:0] FIX_POS_LIM = MAG_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [MAG_W-1:0] FIX_NEG_LIM = MAG_W'(48'h8000_0000_0000);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SIGN    = 3'd1,
    PH_INT     = 3'd2,
    PH_FRAC    = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_SUM  = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

  // One finished literal as handed from the scanner to the converter.
  typedef struct packed {
    logic        invalid;
    logic        minus;
    logic        point;
    logic        ovf;
    logic [31:0] whole;
    logic [29:0] frac;
    logic [3:0]  frac_cnt;
  } lit_rec_t;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/dlp_front.sv
module dlp_front #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_code,
  input  logic             end_of_text,
  input  logic             q_ready,
  output logic             push,
  output dlp_pkg::lit_rec_t rec
);

  dlp_pkg::phase_t phase, phase_next;
  logic        minus_seen, minus_seen_next;
  logic [31:0] whole_acc, whole_acc_next;
  logic [29:0] frac_acc, frac_acc_next;
  logic [3:0]  frac_cnt, frac_cnt_next;
  logic        point_seen, point_seen_next;
  logic        ovf_seen, ovf_seen_next;

  logic        accept;
  logic        is_blank;
  logic        digit_char;
  logic [3:0]  digit_val;
  logic [34:0] whole_prod;
  logic [33:0] frac_prod;
  logic        emit;

  assign in_ready   = q_ready;
  assign accept     = in_valid && in_ready;
  assign is_blank   = (char_code == dlp_pkg::CH_SPACE) || (char_code == dlp_pkg::CH_TAB);
  assign digit_char = char_code inside {[dlp_pkg::CH_ZERO:dlp_pkg::CH_NINE]};
  assign digit_val  = 4'(char_code - dlp_pkg::CH_ZERO);

  // Times ten as two shifts and an add.
  assign whole_prod = ({3'b0, whole_acc} << 3) + ({3'b0, whole_acc} << 1) + {31'b0, digit_val};
  assign frac_prod  = ({4'b0, frac_acc} << 3) + ({4'b0, frac_acc} << 1) + {30'b0, digit_val};

  always_comb begin
    phase_next      = phase;
    minus_seen_next = minus_seen;
    whole_acc_next  = whole_acc;
    frac_acc_next   = frac_acc;
    frac_cnt_next   = frac_cnt;
    point_seen_next = point_seen;
    ovf_seen_next   = ovf_seen;
    emit            = 1'b0;

    if (accept) begin
      if (is_blank) begin
        emit = (phase != dlp_pkg::PH_IDLE);
      end else begin
        case (phase)
          dlp_pkg::PH_IDLE, dlp_pkg::PH_SIGN, dlp_pkg::PH_INT: begin
            if (digit_char) begin
              if (whole_prod > {3'b0, dlp_pkg::WHOLE_CAP}) begin
                whole_acc_next = dlp_pkg::WHOLE_CAP;
                ovf_seen_next  = 1'b1;
              end else begin
                whole_acc_next = whole_prod[31:0];
              end
              phase_next = dlp_pkg::PH_INT;
            end else if (char_code == dlp_pkg::CH_POINT) begin
              point_seen_next = 1'b1;
              phase_next      = dlp_pkg::PH_FRAC;
            end else if (char_code == dlp_pkg::CH_MINUS && phase == dlp_pkg::PH_IDLE) begin
              minus_seen_next = 1'b1;
              phase_next      = dlp_pkg::PH_SIGN;
            end else begin
              phase_next = dlp_pkg::PH_DISCARD;
            end
          end
          dlp_pkg::PH_FRAC: begin
            if (digit_char) begin
              // Digits past the limit are dropped silently.
              if (frac_cnt < 4'(MAX_FRAC_DIGITS)) begin
                frac_acc_next = frac_prod[29:0];
                frac_cnt_next = frac_cnt + 4'd1;
              end
            end else begin
              phase_next = dlp_pkg::PH_DISCARD;
            end
          end
          dlp_pkg::PH_DISCARD: begin
          end
          default: begin
            phase_next = dlp_pkg::PH_IDLE;
          end
        endcase
        if (end_of_text) begin
          emit = 1'b1;
        end
      end
    end

    rec.invalid  = (phase_next == dlp_pkg::PH_DISCARD);
    rec.minus    = minus_seen_next;
    rec.point    = point_seen_next;
    rec.ovf      = ovf_seen_next;
    rec.whole    = whole_acc_next;
    rec.frac     = frac_acc_next;
    rec.frac_cnt = frac_cnt_next;
    push         = emit;

    if (emit) begin
      phase_next      = dlp_pkg::PH_IDLE;
      minus_seen_next = 1'b0;
      whole_acc_next  = '0;
      frac_acc_next   = '0;
      frac_cnt_next   = '0;
      point_seen_next = 1'b0;
      ovf_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dlp_pkg::PH_IDLE;
      minus_seen <= 1'b0;
      whole_acc  <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      point_seen <= 1'b0;
      ovf_seen   <= 1'b0;
    end else begin
      phase      <= phase_next;
      minus_seen <= minus_seen_next;
      whole_acc  <= whole_acc_next;
      frac_acc   <= frac_acc_next;
      frac_cnt   <= frac_cnt_next;
      point_seen <= point_seen_next;
      ovf_seen   <= ovf_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == dlp_pkg::PH_IDLE |-> whole_acc == '0 && frac_acc == '0 && frac_cnt == '0
      && !minus_seen && !point_seen && !ovf_seen)
    else $error("scanner idle with a partial literal held");
  a_frac_cnt: assert property (@(posedge clk) disable iff (rst)
    frac_cnt <= 4'(MAX_FRAC_DIGITS))
    else $error("fraction digit count beyond limit");
  a_whole_cap: assert property (@(posedge clk) disable iff (rst)
    whole_acc <= dlp_pkg::WHOLE_CAP)
    else $error("whole accumulator beyond saturation cap");
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> in_valid && in_ready)
    else $error("literal queued without a character transaction");
`endif

endmodule

FILE: rtl/dlp_queue.sv
module dlp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dlp_pkg::lit_rec_t push_rec,
  output logic              ready,
  output logic              q_valid,
  output dlp_pkg::lit_rec_t q_rec,
  input  logic              pop
);

  dlp_pkg::lit_rec_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign ready   = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_rec   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("literal pushed into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("literal taken from an empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("queue fill count out of range");
`endif

endmodule

FILE: rtl/dlp_back.sv
module dlp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dlp_pkg::lit_rec_t  q_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               real_literal,
  output logic signed [31:0] integer_value,
  output logic signed [47:0] fixed_value,
  output logic [1:0]         parse_status
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 30 + FRAC_BITS + 1;
  localparam int CW = $clog2(QW);
  localparam int MW = dlp_pkg::MAG_W;

  dlp_pkg::back_state_t state, state_next;
  dlp_pkg::lit_rec_t    cur;
  logic [29:0]   rem;
  logic [QW-1:0] dvd_lo;
  logic [QW-1:0] quot;
  logic [CW-1:0] cnt;
  logic [47:0]   mag_r;
  logic [31:0]   ival_r;
  logic [1:0]    status_r;
  logic          real_r;
  logic          load_out;

  logic [29:0]   head_p;
  logic [DW-1:0] dividend;
  logic          need_div;
  logic [29:0]   cur_p;
  logic [30:0]   trial;
  logic          ge;
  logic [30:0]   diff;

  logic [MW-1:0] real_mag;
  logic [31:0]   int_lim;
  logic          int_clip;
  logic [31:0]   im;
  logic [MW-1:0] raw_mag;
  logic [MW-1:0] fix_lim;
  logic          fix_clip;
  logic [MW-1:0] sat_mag;
  logic [31:0]   sum_ival;
  logic          sum_ovf;

  // Rounded fraction: (F * 2^FRAC_BITS + 10^n / 2) / 10^n by restoring division.
  assign head_p   = dlp_pkg::pow10(q_rec.frac_cnt);
  assign dividend = (DW'(q_rec.frac) << FRAC_BITS) + DW'(head_p >> 1);
  assign need_div = !q_rec.invalid && q_rec.point && (q_rec.frac_cnt != 4'd0);

  assign cur_p = dlp_pkg::pow10(cur.frac_cnt);
  assign trial = {rem, dvd_lo[QW-1]};
  assign ge    = (trial >= {1'b0, cur_p});
  assign diff  = trial - {1'b0, cur_p};

  always_comb begin
    real_mag = (MW'(cur.whole) << FRAC_BITS) + MW'(quot);
    int_lim  = cur.minus ? dlp_pkg::WHOLE_CAP : (dlp_pkg::WHOLE_CAP - 32'd1);
    int_clip = (cur.whole > int_lim);
    im       = int_clip ? int_lim : cur.whole;
    raw_mag  = cur.point ? real_mag : (MW'(im) << FRAC_BITS);
    fix_lim  = cur.minus ? dlp_pkg::FIX_NEG_LIM : dlp_pkg::FIX_POS_LIM;
    fix_clip = (raw_mag > fix_lim);
    sat_mag  = fix_clip ? fix_lim : raw_mag;
    sum_ival = cur.point ? 32'd0 : (cur.minus ? (32'd0 - im) : im);
    sum_ovf  = cur.ovf || (!cur.point && int_clip) || fix_clip;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      dlp_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = need_div ? dlp_pkg::BK_DIV : dlp_pkg::BK_SUM;
        end
      end
      dlp_pkg::BK_DIV: begin
        if (cnt == '0) begin
          state_next = dlp_pkg::BK_SUM;
        end
      end
      dlp_pkg::BK_SUM: begin
        state_next = dlp_pkg::BK_DONE;
      end
      dlp_pkg::BK_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = dlp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = dlp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= q_rec;
      rem    <= dividend[DW-1 -: 30];
      dvd_lo <= dividend[QW-1:0];
      quot   <= '0;
      cnt    <= CW'(QW - 1);
    end else if (state == dlp_pkg::BK_DIV) begin
      rem    <= ge ? diff[29:0] : trial[29:0];
      dvd_lo <= dvd_lo << 1;
      quot   <= {quot[QW-2:0], ge};
      cnt    <= cnt - CW'(1);
    end
    if (state == dlp_pkg::BK_SUM) begin
      if (cur.invalid) begin
        mag_r    <= '0;
        ival_r   <= '0;
        status_r <= dlp_pkg::ST_INVALID;
        real_r   <= 1'b0;
      end else begin
        mag_r    <= sat_mag[47:0];
        ival_r   <= sum_ival;
        status_r <= sum_ovf ? dlp_pkg::ST_OVERFLOW : dlp_pkg::ST_OK;
        real_r   <= cur.point;
      end
    end
    if (load_out) begin
      real_literal  <= real_r;
      integer_value <= ival_r;
      fixed_value   <= cur.minus ? (48'd0 - mag_r) : mag_r;
      parse_status  <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == dlp_pkg::BK_DIV |-> rem < cur_p)
    else $error("division remainder not below divisor");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == dlp_pkg::ST_INVALID |->
      fixed_value == '0 && integer_value == '0 && !real_literal)
    else $error("invalid literal carries a value");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == dlp_pkg::BK_DONE && !out_valid |=> out_valid)
    else $error("finished literal not moved to the output register");
`endif

endmodule

FILE: rtl/decimal_literal_parser.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------------
// input    | in_valid / in_ready  | char_code, end_of_text
// output   | out_valid/out_ready  | real_literal, integer_value, fixed_value, parse_status
//
// The scanner takes one character per cycle while the two-entry literal queue has room.
// The converter sends an integer or invalid literal directly to its sum step and a real
// literal with fraction digits first through its one-bit-per-cycle restoring divider.
// A result waits in the output register while the converter works on the next literal.
// Reset clears the scanner, queue and converter control state; there is no clearing pass.
module decimal_literal_parser #(
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               real_literal,
  output logic signed [31:0] integer_value,
  output logic signed [47:0] fixed_value,
  output logic [1:0]         parse_status
);

  logic              q_ready;
  logic              push;
  dlp_pkg::lit_rec_t push_rec;
  logic              q_valid;
  dlp_pkg::lit_rec_t q_rec;
  logic              pop;

  dlp_front #(
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .q_ready    (q_ready),
    .push       (push),
    .rec        (push_rec)
  );

  dlp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .ready   (q_ready),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop)
  );

  dlp_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .real_literal (real_literal),
    .integer_value(integer_value),
    .fixed_value  (fixed_value),
    .parse_status (parse_status)
  );

endmodule

FILE: bench/tb_top.sv
module tb_top;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int RANDOM_CHARS    = 800;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 60;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct {
    logic               point_lit;
    logic signed [31:0] ival;
    logic signed [47:0] fval;
    logic [1:0]         status;
  } literal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_code = 8'd0;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic real_literal;
  logic signed [31:0] integer_value;
  logic signed [47:0] fixed_value;
  logic [1:0] parse_status;

  char_item_t char_stream[$];
  literal_t   parsed_literals[$];
  int chars_sent = 0;
  int chars_taken = 0;
  int total_chars = 1;
  int error_count = 0;
  int cycle_count = 0;

  // Scanner state of the predictor.
  dlp_pkg::phase_t scan_phase;
  logic        lit_minus;
  logic        lit_point;
  logic        lit_ovf;
  logic [31:0] whole_acc;
  logic [29:0] frac_acc;
  logic [3:0]  frac_cnt;

  decimal_literal_parser #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .real_literal(real_literal),
    .integer_value(integer_value),
    .fixed_value(fixed_value),
    .parse_status(parse_status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Share of cycles, in percent, in which one side holds back. The run goes through
  // three thirds: sender mostly busy, then receiver mostly busy, then no idling.
  function automatic int idle_share(bit sender);
    int third;
    third = chars_sent * 3 / total_chars;
    if (third == 0) return sender ? 6 : 73;
    if (third == 1) return sender ? 73 : 6;
    return 0;
  endfunction

  task automatic clear_scan();
    scan_phase = dlp_pkg::PH_IDLE;
    lit_minus  = 1'b0;
    lit_point  = 1'b0;
    lit_ovf    = 1'b0;
    whole_acc  = '0;
    frac_acc   = '0;
    frac_cnt   = '0;
  endtask

  task automatic close_literal();
    literal_t    lit;
    logic [63:0] lim, mag, fracv, p, im, ilim;
    logic        ovf;
    int          n;
    lit = '{point_lit: 1'b0, ival: '0, fval: '0, status: dlp_pkg::ST_OK};
    if (scan_phase == dlp_pkg::PH_DISCARD) begin
      lit.status = dlp_pkg::ST_INVALID;
    end else begin
      ovf = lit_ovf;
      lim = lit_minus ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      if (lit_point) begin
        n = (frac_cnt > 4'd9) ? 9 : int'(frac_cnt);
        fracv = '0;
        if (n > 0) begin
          p = 64'd1;
          for (int i = 0; i < n; i++) p = p * 64'd10;
          fracv = (({34'd0, frac_acc} << FRAC_BITS) + p / 64'd2) / p;
        end
        mag = ({32'd0, whole_acc} << FRAC_BITS) + fracv;
        lit.point_lit = 1'b1;
      end else begin
        ilim = lit_minus ? 64'h8000_0000 : 64'h7FFF_FFFF;
        im = {32'd0, whole_acc};
        if (im > ilim) begin
          im = ilim;
          ovf = 1'b1;
        end
        lit.ival = lit_minus ? 32'(64'd0 - im) : 32'(im);
        mag = im << FRAC_BITS;
      end
      if (mag > lim) begin
        mag = lim;
        ovf = 1'b1;
      end
      lit.fval = lit_minus ? 48'(64'd0 - mag) : 48'(mag);
      lit.status = ovf ? dlp_pkg::ST_OVERFLOW : dlp_pkg::ST_OK;
    end
    parsed_literals.push_back(lit);
    clear_scan();
  endtask

  task automatic add_whole_digit(logic [3:0] d);
    logic [63:0] v;
    v = {32'd0, whole_acc} * 64'd10 + 64'(d);
    if (v > 64'h8000_0000) begin
      v = 64'h8000_0000;
      lit_ovf = 1'b1;
    end
    whole_acc = v[31:0];
  endtask

  task automatic scan_char(logic [7:0] c, logic last);
    logic       digit;
    logic [3:0] d;
    digit = (c >= dlp_pkg::CH_ZERO) && (c <= dlp_pkg::CH_NINE);
    d = digit ? 4'(c - dlp_pkg::CH_ZERO) : 4'd0;
    if (c == dlp_pkg::CH_SPACE || c == dlp_pkg::CH_TAB) begin
      if (scan_phase != dlp_pkg::PH_IDLE) close_literal();
      else clear_scan();
    end else begin
      case (scan_phase)
        dlp_pkg::PH_IDLE, dlp_pkg::PH_SIGN, dlp_pkg::PH_INT: begin
          if (scan_phase == dlp_pkg::PH_IDLE && c == dlp_pkg::CH_MINUS) begin
            lit_minus = 1'b1;
            scan_phase = dlp_pkg::PH_SIGN;
          end else if (digit) begin
            add_whole_digit(d);
            scan_phase = dlp_pkg::PH_INT;
          end else if (c == dlp_pkg::CH_POINT) begin
            lit_point = 1'b1;
            scan_phase = dlp_pkg::PH_FRAC;
          end else begin
            scan_phase = dlp_pkg::PH_DISCARD;
          end
        end
        dlp_pkg::PH_FRAC: begin
          if (!digit) begin
            scan_phase = dlp_pkg::PH_DISCARD;
          end else if (int'(frac_cnt) < MAX_FRAC_DIGITS) begin
            frac_acc = frac_acc * 30'd10 + 30'(d);
            frac_cnt = frac_cnt + 4'd1;
          end
        end
        default: ;
      endcase
      if (last) close_literal();
    end
  endtask

  task automatic push_char(logic [7:0] c, logic last);
    char_stream.push_back('{code: c, last: last});
  endtask

  task automatic push_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) push_char(s[i], last && (i == s.len() - 1));
  endtask

  // A literal built to be well formed, optionally with one bad character slipped in,
  // followed by one or two separators or by the end of the text.
  task automatic add_literal(bit with_fault);
    logic [7:0] lit[$];
    string      edge_vals[4];
    string      s;
    logic [7:0] bad;
    int         sel, n, k, r;
    bit         nines;
    edge_vals = '{"2147483647", "2147483648", "2147483649", "9999999999"};
    if ($urandom_range(9) < 4) lit.push_back(dlp_pkg::CH_MINUS);
    sel = $urandom_range(9);
    if (sel == 0) begin
      s = edge_vals[$urandom_range(3)];
      for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
    end else begin
      n = (sel == 1) ? $urandom_range(9, 11) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++) lit.push_back(dlp_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(1)) begin
      lit.push_back(dlp_pkg::CH_POINT);
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      nines = ($urandom_range(5) == 0);
      for (int i = 0; i < n; i++)
        lit.push_back(nines ? dlp_pkg::CH_NINE : dlp_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    if (with_fault) begin
      case ($urandom_range(3))
        0: bad = dlp_pkg::CH_MINUS;
        1: bad = dlp_pkg::CH_POINT;
        2: bad = 8'($urandom_range(128, 255));
        default: begin
          do bad = 8'($urandom_range(127));
          while (bad == dlp_pkg::CH_SPACE || bad == dlp_pkg::CH_TAB ||
                 (bad >= dlp_pkg::CH_ZERO && bad <= dlp_pkg::CH_NINE));
        end
      endcase
      lit.insert($urandom_range(lit.size()), bad);
    end
    r = $urandom_range(11);
    for (int i = 0; i < lit.size(); i++)
      push_char(lit[i], r == 0 && i == lit.size() - 1);
    if (r == 0 && lit.size() == 0) push_char(dlp_pkg::CH_SPACE, 1'b1);
    else if (r == 1) push_char($urandom_range(1) ? dlp_pkg::CH_SPACE : dlp_pkg::CH_TAB, 1'b1);
    else if (r > 1) begin
      k = $urandom_range(1, 2);
      for (int i = 0; i < k; i++)
        push_char($urandom_range(1) ? dlp_pkg::CH_SPACE : dlp_pkg::CH_TAB, 1'b0);
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)), $urandom_range(19) == 0);
    push_char(dlp_pkg::CH_SPACE, 1'b0);
  endtask

  // Sender: a new transaction is offered only once the previous one has gone.
  always @(posedge clk) begin : char_driver
    char_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (char_stream.size() > 0 && $urandom_range(99) >= idle_share(1'b1)) begin
        item = char_stream.pop_front();
        in_valid <= 1'b1;
        char_code <= item.code;
        end_of_text <= item.last;
        chars_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= idle_share(1'b0));
  end

  always @(posedge clk) begin : literal_monitor
    literal_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (parsed_literals.size() == 0) begin
          report("result with no literal pending", {62'd0, parse_status}, 64'd0);
        end else begin
          want = parsed_literals.pop_front();
          if (real_literal !== want.point_lit)
            report("real_literal", {63'd0, real_literal}, {63'd0, want.point_lit});
          if (integer_value !== want.ival)
            report("integer_value", {32'd0, integer_value}, {32'd0, want.ival});
          if (fixed_value !== want.fval)
            report("fixed_value", {16'd0, fixed_value}, {16'd0, want.fval});
          if (parse_status !== want.status)
            report("parse_status", {62'd0, parse_status}, {62'd0, want.status});
        end
      end
      if (in_valid && in_ready) begin
        scan_char(char_code, end_of_text);
        chars_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int directed;
    int kind;
    clear_scan();
    // Directed text: end of text with nothing open, the lone sign and point, codes
    // 0 and 255, a negative real, a misplaced minus sign and a second point.
    push_text(" ", 1'b1);
    push_text("-", 1'b1);
    push_text(". ", 1'b0);
    push_char(8'h00, 1'b1);
    push_text("-1.5\t", 1'b0);
    push_char(8'hFF, 1'b0);
    push_text(" ", 1'b0);
    push_text("1- ", 1'b0);
    push_text(".1. ", 1'b0);
    push_text("7", 1'b1);
    directed = char_stream.size();
    while (char_stream.size() < directed + RANDOM_CHARS) begin
      kind = $urandom_range(9);
      if (kind < 8) add_literal(1'b0);
      else if (kind == 8) add_literal(1'b1);
      else add_noise();
    end
    push_char(dlp_pkg::CH_SPACE, 1'b1);
    total_chars = char_stream.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every character must have been taken before the outstanding literals are counted.
    while (chars_taken < total_chars) @(posedge clk);
    while (parsed_literals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
